// ----- src/fmgc_pkg.sv -----
// Shared types, event codes and constants for the fan mode and gear controller.
package fmgc_pkg;

    // Fixed field widths
    localparam int unsigned EVENT_W = 4;
    localparam int unsigned VALUE_W = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned GEAR_W  = 3;
    localparam int unsigned SPEED_W = 7;
    localparam int unsigned HOURS_W = 3;
    localparam int unsigned TIMER_W = 4;

    // Default number of gears; at most eight are ever used
    localparam int unsigned GEAR_COUNT_DEF = 8;
    localparam int unsigned GEAR_TABLE_N   = 8;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_POWER_KEY    = 4'd0;
    localparam logic [EVENT_W-1:0] EV_MODE_KEY     = 4'd1;
    localparam logic [EVENT_W-1:0] EV_TIMING_KEY   = 4'd2;
    localparam logic [EVENT_W-1:0] EV_CONFIRM_EXP  = 4'd3;
    localparam logic [EVENT_W-1:0] EV_SHUTDOWN_TCK = 4'd4;
    localparam logic [EVENT_W-1:0] EV_NATURE_TCK   = 4'd5;
    localparam logic [EVENT_W-1:0] EV_SLEEP_TCK    = 4'd6;
    localparam logic [EVENT_W-1:0] EV_CLOUD_POWER  = 4'd7;
    localparam logic [EVENT_W-1:0] EV_CLOUD_MODE   = 4'd8;
    localparam logic [EVENT_W-1:0] EV_CLOUD_SPEED  = 4'd9;
    localparam logic [EVENT_W-1:0] EV_CLOUD_TIMING = 4'd10;
    localparam logic [EVENT_W-1:0] EV_CLOUD_BRIGHT = 4'd11;
    localparam logic [EVENT_W-1:0] EV_RESET        = 4'd12;

    // Fan modes
    localparam logic [MODE_W-1:0] FM_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] FM_NATURE = 2'd1;
    localparam logic [MODE_W-1:0] FM_SLEEP  = 2'd2;

    // Timer running flags
    localparam logic [TIMER_W-1:0] TMR_NATURE   = 4'b0001;
    localparam logic [TIMER_W-1:0] TMR_SLEEP    = 4'b0010;
    localparam logic [TIMER_W-1:0] TMR_CONFIRM  = 4'b0100;
    localparam logic [TIMER_W-1:0] TMR_SHUTDOWN = 4'b1000;

    // Gears used by nature mode, timing and speed limits
    localparam logic [GEAR_W-1:0]  NATURE_SLOW   = 3'd1;
    localparam logic [GEAR_W-1:0]  NATURE_FAST   = 3'd6;
    localparam logic [HOURS_W-1:0] TIMING_MAX    = 3'd4;
    localparam logic [SPEED_W-1:0] SPEED_DEFAULT = 7'd10;
    localparam logic [SPEED_W-1:0] SPEED_MAX     = 7'd100;

    // Speed percent for each gear
    localparam logic [SPEED_W-1:0] SPEED_TABLE [GEAR_TABLE_N] = '{
        7'd10, 7'd20, 7'd35, 7'd55, 7'd60, 7'd75, 7'd85, 7'd100
    };

    // Architectural state of the fan
    typedef struct packed {
        logic               power;
        logic [MODE_W-1:0]  fan_mode;
        logic [GEAR_W-1:0]  gear;
        logic [SPEED_W-1:0] speed;
        logic [HOURS_W-1:0] hours;
        logic [HOURS_W-1:0] pending;
        logic               show_timing;
        logic               bright;
        logic [TIMER_W-1:0] timers;
    } t_fan_state;

    // State after one event together with its requests
    typedef struct packed {
        t_fan_state state;
        logic       save;
        logic       report;
    } t_step_result;

    localparam t_fan_state FAN_STATE_RESET = '{
        power:       1'b0,
        fan_mode:    FM_NORMAL,
        gear:        '0,
        speed:       SPEED_DEFAULT,
        hours:       '0,
        pending:     '0,
        show_timing: 1'b0,
        bright:      1'b0,
        timers:      '0
    };

endpackage

// ----- src/fan_mode_gear_controller.sv -----
// Top level of the fan mode and gear controller: request registers and fan state.
// Each request on the slave stream is one fan event (key, timer tick, cloud command
// or reset) and yields exactly one status item on the master stream, with the full
// fan status and one-shot save and report flags. A request is taken every clock
// cycle while the master side keeps up; an accepted request sits in the input
// register while the event logic works on it, and its status item enters the status
// register when that register is free or drains; the fan state is updated at the
// same edge so that the next request sees it. The input register refills while a
// finished status item still waits to be taken.
module fan_mode_gear_controller #(
    parameter int unsigned GEAR_COUNT = fmgc_pkg::GEAR_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event requests
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // mode[3:0], value[11:4], zero[15:12]
    // Status results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_power[0], out_mode[2:1], out_gear[5:3], out_speed[12:6], out_timing[15:13],
    // out_timing_shown[18:16], out_show_timing[19], out_bright[20],
    // save_request[21], report_request[22], zero[23]
    output logic [23:0] o_m_tdata
);
    import fmgc_pkg::*;

    logic               r_in_valid;
    logic [EVENT_W-1:0] r_in_event;
    logic [VALUE_W-1:0] r_in_value;
    logic               r_out_valid;
    logic [23:0]        r_out_data;
    logic [23:0]        n_out_data;
    t_fan_state         r_state;
    t_step_result       step;
    logic               advance;

    // An event moves into the status register when that register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_event <= i_s_tdata[EVENT_W-1:0];
            r_in_value <= i_s_tdata[EVENT_W+VALUE_W-1:EVENT_W];
        end
    end

    // Event logic
    fmgc_step #(
        .GEAR_COUNT (GEAR_COUNT)
    ) u_step (
        .i_state  (r_state),
        .i_event  (r_in_event),
        .i_value  (r_in_value),
        .o_result (step)
    );

    // Fan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FAN_STATE_RESET;
        end else if (advance) begin
            r_state <= step.state;
        end
    end

    // Pack the status item; speed reads zero while the fan is off
    always_comb begin
        n_out_data = {
            1'b0,
            step.report,
            step.save,
            step.state.bright,
            step.state.show_timing,
            step.state.pending,
            step.state.hours,
            (step.state.power ? step.state.speed : SPEED_W'(0)),
            step.state.gear,
            step.state.fan_mode,
            step.state.power
        };
    end

    // Status register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- src/fmgc_step.sv -----
// Next-state logic: applies one event to the fan state and raises the requests.
module fmgc_step #(
    parameter int unsigned GEAR_COUNT = fmgc_pkg::GEAR_COUNT_DEF
) (
    input  fmgc_pkg::t_fan_state         i_state,
    input  logic [fmgc_pkg::EVENT_W-1:0] i_event,
    input  logic [fmgc_pkg::VALUE_W-1:0] i_value,
    output fmgc_pkg::t_step_result       o_result
);
    import fmgc_pkg::*;

    // Number of gears in use and the highest gear index
    localparam int unsigned GEAR_LIMIT = (GEAR_COUNT > GEAR_TABLE_N) ? GEAR_TABLE_N :
                                         (GEAR_COUNT < 1) ? 1 : GEAR_COUNT;
    localparam logic [GEAR_W:0]   GEAR_LIM_W = (GEAR_W+1)'(GEAR_LIMIT);
    localparam logic [GEAR_W-1:0] GEAR_TOP   = GEAR_W'(GEAR_LIMIT - 1);

    // Saturate a gear index to the gears in use
    function automatic logic [GEAR_W-1:0] clip_gear(input logic [GEAR_W-1:0] g);
        return ({1'b0, g} >= GEAR_LIM_W) ? GEAR_TOP : g;
    endfunction

    // Enter the current mode: set its timers, gear and speed
    function automatic t_fan_state apply_mode(input t_fan_state s_in);
        t_fan_state s;
        s = s_in;
        case (s.fan_mode)
            FM_NORMAL: begin
                s.timers = s.timers & ~(TMR_NATURE | TMR_SLEEP);
                s.gear   = clip_gear(s.gear);
                s.speed  = SPEED_TABLE[s.gear];
            end
            FM_NATURE: begin
                s.timers = (s.timers & ~TMR_SLEEP) | TMR_NATURE;
                s.gear   = clip_gear(NATURE_FAST);
                s.speed  = SPEED_TABLE[s.gear];
            end
            FM_SLEEP: begin
                s.timers = s.timers & ~TMR_NATURE;
                s.gear   = clip_gear(s.gear);
                s.speed  = SPEED_TABLE[s.gear];
                if (s.gear != '0) begin
                    s.timers = s.timers | TMR_SLEEP;
                end
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    // Follow a change of the power flag
    function automatic t_fan_state apply_power(input t_fan_state s_in);
        t_fan_state s;
        s = s_in;
        if (s.power) begin
            if (s.hours != '0) begin
                s.timers = s.timers | TMR_SHUTDOWN;
            end
            s = apply_mode(s);
        end else begin
            s.timers      = '0;
            s.show_timing = 1'b0;
        end
        return s;
    endfunction

    t_fan_state         s;
    logic               save;
    logic               report;
    logic [SPEED_W-1:0] cloud_speed;
    logic [GEAR_W-1:0]  cloud_gear;
    logic [HOURS_W-1:0] hours_dec;

    // Gear for a cloud speed: first table entry not below it, else the top gear
    always_comb begin
        cloud_speed = (i_value > VALUE_W'(SPEED_MAX)) ? SPEED_MAX : i_value[SPEED_W-1:0];
        cloud_gear  = GEAR_TOP;
        for (int i = GEAR_TABLE_N - 1; i >= 0; i--) begin
            if ((i < GEAR_LIMIT) && (cloud_speed <= SPEED_TABLE[i])) begin
                cloud_gear = GEAR_W'(i);
            end
        end
    end

    // Event decode and state update
    always_comb begin
        s         = i_state;
        save      = 1'b0;
        report    = 1'b0;
        hours_dec = (i_state.hours != '0) ? i_state.hours - 1'b1 : i_state.hours;
        case (i_event)
            EV_POWER_KEY: begin
                s.power = ~i_state.power;
                s       = apply_power(s);
                save    = 1'b1;
                report  = 1'b1;
            end
            EV_MODE_KEY: begin
                if (i_state.power) begin
                    s.fan_mode = (i_state.fan_mode >= FM_SLEEP) ? FM_NORMAL
                                                                : i_state.fan_mode + 1'b1;
                    s      = apply_mode(s);
                    save   = 1'b1;
                    report = 1'b1;
                end
            end
            EV_TIMING_KEY: begin
                if (i_state.power) begin
                    if (!i_state.show_timing) begin
                        s.pending     = i_state.hours;
                        s.show_timing = 1'b1;
                    end else begin
                        s.pending = (i_state.pending >= TIMING_MAX) ? '0
                                                                    : i_state.pending + 1'b1;
                    end
                    s.timers = s.timers | TMR_CONFIRM;
                end
            end
            EV_CONFIRM_EXP: begin
                if ((i_state.timers & TMR_CONFIRM) != '0) begin
                    s.timers = s.timers & ~TMR_CONFIRM;
                    if (i_state.hours != i_state.pending) begin
                        s.hours  = i_state.pending;
                        report   = 1'b1;
                        s.timers = s.timers & ~TMR_SHUTDOWN;
                        if (i_state.pending != '0) begin
                            s.timers = s.timers | TMR_SHUTDOWN;
                        end
                    end
                    s.show_timing = 1'b0;
                end
            end
            EV_SHUTDOWN_TCK: begin
                if ((i_state.timers & TMR_SHUTDOWN) != '0) begin
                    s.hours   = hours_dec;
                    s.pending = hours_dec;
                    if (hours_dec == '0) begin
                        s.power = 1'b0;
                        s       = apply_power(s);
                    end
                    save   = 1'b1;
                    report = 1'b1;
                end
            end
            EV_NATURE_TCK: begin
                if ((i_state.timers & TMR_NATURE) != '0) begin
                    s.gear  = clip_gear((i_state.gear == clip_gear(NATURE_SLOW)) ? NATURE_FAST
                                                                                 : NATURE_SLOW);
                    s.speed = SPEED_TABLE[s.gear];
                    save    = 1'b1;
                    report  = 1'b1;
                end
            end
            EV_SLEEP_TCK: begin
                if ((i_state.timers & TMR_SLEEP) != '0) begin
                    s.gear  = clip_gear((i_state.gear != '0) ? i_state.gear - 1'b1 : '0);
                    s.speed = SPEED_TABLE[s.gear];
                    if (s.gear == '0) begin
                        s.timers = s.timers & ~TMR_SLEEP;
                    end
                    save   = 1'b1;
                    report = 1'b1;
                end
            end
            EV_CLOUD_POWER: begin
                if ((i_value != '0) != i_state.power) begin
                    s.power = (i_value != '0);
                    s       = apply_power(s);
                    save    = 1'b1;
                    report  = 1'b1;
                end
            end
            EV_CLOUD_MODE: begin
                if (i_state.power && (i_value <= VALUE_W'(FM_SLEEP))
                        && (i_value != VALUE_W'(i_state.fan_mode))) begin
                    s.fan_mode = i_value[MODE_W-1:0];
                    s          = apply_mode(s);
                    save       = 1'b1;
                    report     = 1'b1;
                end
            end
            EV_CLOUD_SPEED: begin
                if (i_state.power) begin
                    s.speed = cloud_speed;
                    s.gear  = cloud_gear;
                    if (i_state.fan_mode == FM_NATURE) begin
                        s.fan_mode = FM_NORMAL;
                        s.timers   = s.timers & ~TMR_NATURE;
                    end
                    if (i_state.fan_mode == FM_SLEEP) begin
                        s.timers = s.timers | TMR_SLEEP;
                    end
                    save = 1'b1;
                end
            end
            EV_CLOUD_TIMING: begin
                if (i_state.power && (i_value != VALUE_W'(i_state.hours))) begin
                    s.hours  = (i_value > VALUE_W'(TIMING_MAX)) ? TIMING_MAX
                                                                : i_value[HOURS_W-1:0];
                    s.timers = s.timers & ~TMR_SHUTDOWN;
                    if (i_value != '0) begin
                        s.timers = s.timers | TMR_SHUTDOWN;
                    end
                end
            end
            EV_CLOUD_BRIGHT: begin
                if (i_value <= VALUE_W'(1)) begin
                    s.bright = i_value[0];
                end
            end
            EV_RESET: begin
                s      = apply_power(FAN_STATE_RESET);
                save   = 1'b1;
                report = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_result = '{state: s, save: save, report: report};

endmodule

// ----- sim/tb_fan_mode_gear_controller.sv -----
// Self-checking testbench for the fan mode and gear controller event stream.
`timescale 1ns / 1ps

module tb_fan_mode_gear_controller;
    import fmgc_pkg::*;

    // Gears actually in use: the table caps the count at eight.
    localparam int unsigned N_GEARS = (GEAR_COUNT_DEF > GEAR_TABLE_N) ? GEAR_TABLE_N :
                                      (GEAR_COUNT_DEF < 1) ? 1 : GEAR_COUNT_DEF;

    // Event codes the block leaves without effect.
    localparam logic [EVENT_W-1:0] EV_SPARE_FIRST = 4'd13;
    localparam logic [EVENT_W-1:0] EV_SPARE_LAST  = 4'd15;

    localparam int unsigned RANDOM_EVENTS = 1260;
    localparam int unsigned IDLE_PCT      = 35;
    localparam int unsigned STEADY_FROM   = 800;
    localparam int unsigned STEADY_TO     = 1400;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // mode[3:0], value[11:4], zero[15:12]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // out_power[0], out_mode[2:1], out_gear[5:3], out_speed[12:6], out_timing[15:13],
    // out_timing_shown[18:16], out_show_timing[19], out_bright[20],
    // save_request[21], report_request[22], zero[23]
    logic [23:0] o_m_tdata;

    // Event requests waiting to be sent and status items waiting to arrive.
    logic [15:0]  event_q[$];
    t_step_result status_q[$];

    // Predicted fan state and the requests of the event being worked out.
    t_fan_state   fan = FAN_STATE_RESET;
    logic         want_save;
    logic         want_report;
    t_step_result next_status;
    t_step_result status_want;

    int unsigned mismatches = 0;
    int unsigned cyc        = 0;
    logic        steady;

    fan_mode_gear_controller #(
        .GEAR_COUNT(GEAR_COUNT_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle count; one window of the run goes without any idling.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end
    assign steady = (cyc >= STEADY_FROM) && (cyc < STEADY_TO);

    // Gear index limited to the gears in use.
    function automatic logic [GEAR_W-1:0] gear_clip(input int unsigned g);
        int unsigned c;
        c = (g >= N_GEARS) ? N_GEARS - 1 : g;
        return c[GEAR_W-1:0];
    endfunction

    // Speed follows the (clipped) gear.
    task automatic gear_load();
        fan.gear  = gear_clip(fan.gear);
        fan.speed = SPEED_TABLE[fan.gear];
    endtask

    // Enter the current fan mode, setting gear and mode timers.
    task automatic mode_enter();
        case (fan.fan_mode)
            FM_NORMAL: begin
                fan.timers &= ~(TMR_NATURE | TMR_SLEEP);
                gear_load();
            end
            FM_NATURE: begin
                fan.timers &= ~TMR_SLEEP;
                fan.gear = gear_clip(NATURE_FAST);
                gear_load();
                fan.timers |= TMR_NATURE;
            end
            FM_SLEEP: begin
                fan.timers &= ~TMR_NATURE;
                gear_load();
                if (fan.gear != '0) fan.timers |= TMR_SLEEP;
            end
            default: begin
            end
        endcase
        want_save   = 1'b1;
        want_report = 1'b1;
    endtask

    // Bring the rest of the state in line with the power flag.
    task automatic power_follow();
        if (fan.power) begin
            if (fan.hours != '0) fan.timers |= TMR_SHUTDOWN;
            mode_enter();
        end else begin
            fan.timers      = '0;
            fan.show_timing = 1'b0;
        end
        want_save   = 1'b1;
        want_report = 1'b1;
    endtask

    // Predict the status item that one event produces.
    task automatic fan_event_apply(input logic [EVENT_W-1:0] ev,
                                   input logic [VALUE_W-1:0] v,
                                   output t_step_result res);
        logic [SPEED_W-1:0] sp;
        logic               found;
        want_save   = 1'b0;
        want_report = 1'b0;
        case (ev)
            EV_POWER_KEY: begin
                fan.power = ~fan.power;
                power_follow();
            end
            EV_MODE_KEY: begin
                if (fan.power) begin
                    fan.fan_mode = (fan.fan_mode >= FM_SLEEP) ? FM_NORMAL : fan.fan_mode + 1'b1;
                    mode_enter();
                end
            end
            EV_TIMING_KEY: begin
                if (fan.power) begin
                    if (!fan.show_timing) begin
                        fan.pending     = fan.hours;
                        fan.show_timing = 1'b1;
                    end else begin
                        fan.pending = (fan.pending >= TIMING_MAX) ? '0 : fan.pending + 1'b1;
                    end
                    fan.timers |= TMR_CONFIRM;
                end
            end
            EV_CONFIRM_EXP: begin
                if ((fan.timers & TMR_CONFIRM) != '0) begin
                    fan.timers &= ~TMR_CONFIRM;
                    if (fan.hours != fan.pending) begin
                        fan.hours   = fan.pending;
                        want_report = 1'b1;
                        fan.timers &= ~TMR_SHUTDOWN;
                        if (fan.hours != '0) fan.timers |= TMR_SHUTDOWN;
                    end
                    fan.show_timing = 1'b0;
                end
            end
            EV_SHUTDOWN_TCK: begin
                if ((fan.timers & TMR_SHUTDOWN) != '0) begin
                    if (fan.hours != '0) fan.hours = fan.hours - 1'b1;
                    fan.pending = fan.hours;
                    if (fan.hours == '0) begin
                        fan.power = 1'b0;
                        power_follow();
                    end else begin
                        want_save   = 1'b1;
                        want_report = 1'b1;
                    end
                end
            end
            EV_NATURE_TCK: begin
                if ((fan.timers & TMR_NATURE) != '0) begin
                    fan.gear = (fan.gear == gear_clip(NATURE_SLOW)) ? gear_clip(NATURE_FAST)
                                                                    : gear_clip(NATURE_SLOW);
                    gear_load();
                    want_save   = 1'b1;
                    want_report = 1'b1;
                end
            end
            EV_SLEEP_TCK: begin
                if ((fan.timers & TMR_SLEEP) != '0) begin
                    if (fan.gear != '0) fan.gear = fan.gear - 1'b1;
                    gear_load();
                    if (fan.gear == '0) fan.timers &= ~TMR_SLEEP;
                    want_save   = 1'b1;
                    want_report = 1'b1;
                end
            end
            EV_CLOUD_POWER: begin
                if ((v != '0) != fan.power) begin
                    fan.power = (v != '0);
                    power_follow();
                end
            end
            EV_CLOUD_MODE: begin
                if (fan.power && v <= {6'b0, FM_SLEEP} && v[MODE_W-1:0] != fan.fan_mode) begin
                    fan.fan_mode = v[MODE_W-1:0];
                    mode_enter();
                end
            end
            EV_CLOUD_SPEED: begin
                if (fan.power) begin
                    // Saturate, then pick the first gear fast enough for it.
                    sp        = (v > {1'b0, SPEED_MAX}) ? SPEED_MAX : v[SPEED_W-1:0];
                    fan.speed = sp;
                    fan.gear  = gear_clip(N_GEARS - 1);
                    found     = 1'b0;
                    for (int i = 0; i < N_GEARS; i++) begin
                        if (!found && sp <= SPEED_TABLE[i]) begin
                            fan.gear = gear_clip(i);
                            found    = 1'b1;
                        end
                    end
                    if (fan.fan_mode == FM_NATURE) begin
                        fan.fan_mode = FM_NORMAL;
                        fan.timers &= ~TMR_NATURE;
                    end
                    if (fan.fan_mode == FM_SLEEP) fan.timers |= TMR_SLEEP;
                    want_save = 1'b1;
                end
            end
            EV_CLOUD_TIMING: begin
                if (fan.power && v != {5'b0, fan.hours}) begin
                    fan.hours = (v > {5'b0, TIMING_MAX}) ? TIMING_MAX : v[HOURS_W-1:0];
                    fan.timers &= ~TMR_SHUTDOWN;
                    if (fan.hours != '0) fan.timers |= TMR_SHUTDOWN;
                end
            end
            EV_CLOUD_BRIGHT: begin
                if (v <= 8'd1) fan.bright = v[0];
            end
            EV_RESET: begin
                fan = FAN_STATE_RESET;
                power_follow();
            end
            default: begin
            end
        endcase
        res.state = fan;
        if (!fan.power) res.state.speed = '0;
        res.save   = want_save;
        res.report = want_report;
    endtask

    task automatic queue_event(input logic [EVENT_W-1:0] ev, input logic [VALUE_W-1:0] v);
        event_q.push_back({4'b0, v, ev});
    endtask

    // Random event, weighted so the fan stays powered most of the time.
    function automatic logic [15:0] random_event();
        int unsigned        pick;
        logic [EVENT_W-1:0] ev;
        logic [VALUE_W-1:0] v;
        pick = $urandom_range(0, 99);
        v    = VALUE_W'($urandom_range(0, 255));
        if (pick < 6) begin
            ev = EV_POWER_KEY;
        end else if (pick < 16) begin
            ev = EV_MODE_KEY;
        end else if (pick < 28) begin
            ev = EV_TIMING_KEY;
        end else if (pick < 38) begin
            ev = EV_CONFIRM_EXP;
        end else if (pick < 46) begin
            ev = EV_SHUTDOWN_TCK;
        end else if (pick < 56) begin
            ev = EV_NATURE_TCK;
        end else if (pick < 64) begin
            ev = EV_SLEEP_TCK;
        end else if (pick < 70) begin
            ev = EV_CLOUD_POWER;
            if (pick < 66) v = '0;
        end else if (pick < 78) begin
            ev = EV_CLOUD_MODE;
            if (pick < 76) v = VALUE_W'($urandom_range(0, 2));
        end else if (pick < 86) begin
            ev = EV_CLOUD_SPEED;
            if (pick < 84) v = VALUE_W'($urandom_range(0, 100));
        end else if (pick < 92) begin
            ev = EV_CLOUD_TIMING;
            if (pick < 90) v = VALUE_W'($urandom_range(0, 5));
        end else if (pick < 96) begin
            ev = EV_CLOUD_BRIGHT;
            if (pick < 95) v = VALUE_W'($urandom_range(0, 1));
        end else if (pick < 97) begin
            ev = EV_RESET;
        end else begin
            ev = EVENT_W'($urandom_range(EV_SPARE_FIRST, EV_SPARE_LAST));
        end
        return {4'b0, v, ev};
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Hold until every queued request has been sent and every status item has come back.
    // The check is made at the falling edge, once the driver's updates have settled.
    task automatic wait_drained();
        while (event_q.size() != 0 || i_s_tvalid || status_q.size() != 0) @(negedge i_clk);
    endtask

    // Request driver: predict on acceptance, then offer the next request or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                fan_event_apply(i_s_tdata[EVENT_W-1:0], i_s_tdata[EVENT_W+VALUE_W-1:EVENT_W],
                                next_status);
                status_q.push_back(next_status);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (event_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_s_tdata  <= event_q.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Status monitor: compare each accepted status item with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (status_q.size() == 0) begin
                    $error("status item 0x%06h arrived with no event outstanding", o_m_tdata);
                    mismatches++;
                end else begin
                    status_want = status_q.pop_front();
                    check_field("out_power", status_want.state.power, o_m_tdata[0]);
                    check_field("out_mode", status_want.state.fan_mode, o_m_tdata[2:1]);
                    check_field("out_gear", status_want.state.gear, o_m_tdata[5:3]);
                    check_field("out_speed", status_want.state.speed, o_m_tdata[12:6]);
                    check_field("out_timing", status_want.state.hours, o_m_tdata[15:13]);
                    check_field("out_timing_shown", status_want.state.pending, o_m_tdata[18:16]);
                    check_field("out_show_timing", status_want.state.show_timing, o_m_tdata[19]);
                    check_field("out_bright", status_want.state.bright, o_m_tdata[20]);
                    check_field("save_request", status_want.save, o_m_tdata[21]);
                    check_field("report_request", status_want.report, o_m_tdata[22]);
                end
            end
            i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus: directed corner cases, then two random batches with a full drain between.
    initial begin
        // Keys and cloud commands while off, brightness and spare codes.
        queue_event(EV_MODE_KEY, 8'h00);
        queue_event(EV_CLOUD_SPEED, 8'd200);
        queue_event(EV_CLOUD_BRIGHT, 8'd2);
        queue_event(EV_CLOUD_BRIGHT, 8'd1);
        queue_event(EV_SPARE_LAST, 8'hFF);
        queue_event(EV_CLOUD_POWER, 8'h00);
        queue_event(EV_CLOUD_POWER, 8'h80);
        // Nature mode alternation, unknown cloud mode, sleep step-down.
        queue_event(EV_MODE_KEY, 8'hFF);
        queue_event(EV_NATURE_TCK, 8'h00);
        queue_event(EV_NATURE_TCK, 8'h00);
        queue_event(EV_CLOUD_MODE, 8'd3);
        queue_event(EV_CLOUD_MODE, {6'b0, FM_SLEEP});
        queue_event(EV_SLEEP_TCK, 8'h00);
        // Speed saturation and the slowest gear.
        queue_event(EV_CLOUD_SPEED, 8'd255);
        queue_event(EV_CLOUD_SPEED, 8'd0);
        // Timing saturation, unchanged timing, key cycling and shutdown to zero.
        queue_event(EV_CLOUD_TIMING, 8'd200);
        queue_event(EV_CLOUD_TIMING, 8'd4);
        queue_event(EV_TIMING_KEY, 8'h00);
        queue_event(EV_TIMING_KEY, 8'h00);
        queue_event(EV_TIMING_KEY, 8'h00);
        queue_event(EV_CONFIRM_EXP, 8'h00);
        queue_event(EV_SHUTDOWN_TCK, 8'h00);
        queue_event(EV_POWER_KEY, 8'h00);
        queue_event(EV_RESET, 8'h00);
        queue_event(EV_CLOUD_BRIGHT, 8'd0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        for (int k = 0; k < RANDOM_EVENTS / 2; k++) event_q.push_back(random_event());
        wait_drained();
        for (int k = 0; k < RANDOM_EVENTS / 2; k++) event_q.push_back(random_event());
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog against a stalled stream.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/fmgc_pkg.sv
src/fmgc_step.sv
src/fan_mode_gear_controller.sv
sim/tb_fan_mode_gear_controller.sv
